/* sv/great_circle_radius_filter_unit_macros.svh */
// Assertion helpers for the checker file.
`ifndef GREAT_CIRCLE_RADIUS_FILTER_UNIT_MACROS_SVH
`define GREAT_CIRCLE_RADIUS_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GCRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GCRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/gcrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gcrf_pkg;

   localparam int LAT_W  = 28;
   localparam int LNG_W  = 29;
   localparam int DIST_W = 25;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 29;

   localparam int CORDIC_STAGES_DEF = 24;

   // internal Q2.30 angle and vector width
   localparam int CW = 34;
   // multiplier operand width
   localparam int MW = 32;
   // width of a (0 .. 2^30)
   localparam int AW = 31;
   localparam int ROOT_W = 31;
   localparam int REM_W  = 61;

   localparam int ROT_LANES  = 4;
   localparam int SQRT_LANES = 2;

   typedef logic signed [CW-1:0] cw_type;

   typedef struct packed {
      logic valid;
      logic has_pos;
   } ctl_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_CENTER_LAT = 2'd0,
      CSR_CENTER_LNG = 2'd1,
      CSR_RADIUS     = 2'd2
   } csr_idx_type;

   localparam logic signed [LAT_W-1:0] LAT_LIMIT = 28'sd90000000;
   localparam logic signed [31:0] LNG_HALF_TURN = 32'sd180000000;
   localparam logic signed [31:0] LNG_TURN      = 32'sd360000000;
   localparam logic [DIST_W-1:0] DIST_MAX = 25'd20015087;
   localparam logic [22:0] EARTH_RADIUS_M = 23'd6371000;

   localparam cw_type CORDIC_INV_GAIN = 34'sd652032874;
   localparam logic [AW-1:0] Q30_ONE = 31'h4000_0000;

   // microdegrees to radians, Q58, split in two partial products
   localparam logic [63:0] DEG_TO_RAD_Q28 = 64'd5030569069;
   localparam logic signed [17:0] DEG_RAD_HI = 18'(DEG_TO_RAD_Q28 >> 16);
   localparam logic signed [16:0] DEG_RAD_LO = 17'(DEG_TO_RAD_Q28 & 64'hFFFF);

   localparam cw_type ATAN_LEAD [10] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
      34'sd4194282,   34'sd2097149
   };

   function automatic cw_type atan_q30(input int i);
      cw_type r;
      if (i < 10) begin
         r = ATAN_LEAD[i];
      end else if (i < 30) begin
         r = cw_type'((64'sd1 <<< (30 - i)) - 64'sd1);
      end else begin
         r = '0;
      end
      return r;
   endfunction

   function automatic logic signed [LAT_W-1:0] clamp_lat(input logic signed [LAT_W-1:0] v);
      logic signed [LAT_W-1:0] r;
      if (v > LAT_LIMIT) begin
         r = LAT_LIMIT;
      end else if (v < -LAT_LIMIT) begin
         r = -LAT_LIMIT;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/gcrf_cordic_rot.sv */
`timescale 1ns / 1ps
`default_nettype none
module gcrf_cordic_rot #(
   parameter int STAGES = gcrf_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  gcrf_pkg::ctl_type in_ctl,
   input  gcrf_pkg::cw_type  in_theta [gcrf_pkg::ROT_LANES],
   output gcrf_pkg::ctl_type out_ctl,
   output gcrf_pkg::cw_type  out_cos  [gcrf_pkg::ROT_LANES],
   output gcrf_pkg::cw_type  out_sin  [gcrf_pkg::ROT_LANES]
);

   localparam int L = gcrf_pkg::ROT_LANES;

   gcrf_pkg::cw_type  x_ff [STAGES][L];
   gcrf_pkg::cw_type  y_ff [STAGES][L];
   gcrf_pkg::cw_type  z_ff [STAGES][L];
   gcrf_pkg::ctl_type ctl_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam gcrf_pkg::cw_type ATAN_S = gcrf_pkg::atan_q30(s);
      gcrf_pkg::cw_type  x_prev [L];
      gcrf_pkg::cw_type  y_prev [L];
      gcrf_pkg::cw_type  z_prev [L];
      gcrf_pkg::ctl_type ctl_prev;
      gcrf_pkg::cw_type  x_in [L];
      gcrf_pkg::cw_type  y_in [L];
      gcrf_pkg::cw_type  z_in [L];

      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < L; l++) begin
               x_prev[l] = gcrf_pkg::CORDIC_INV_GAIN;
               y_prev[l] = '0;
               z_prev[l] = in_theta[l];
            end
            ctl_prev = in_ctl;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < L; l++) begin
               x_prev[l] = x_ff[s-1][l];
               y_prev[l] = y_ff[s-1][l];
               z_prev[l] = z_ff[s-1][l];
            end
            ctl_prev = ctl_ff[s-1];
         end
      end

      // rotate toward z = 0
      always_comb begin
         for (int l = 0; l < L; l++) begin
            if (z_prev[l] >= 0) begin
               x_in[l] = x_prev[l] - (y_prev[l] >>> s);
               y_in[l] = y_prev[l] + (x_prev[l] >>> s);
               z_in[l] = z_prev[l] - ATAN_S;
            end else begin
               x_in[l] = x_prev[l] + (y_prev[l] >>> s);
               y_in[l] = y_prev[l] - (x_prev[l] >>> s);
               z_in[l] = z_prev[l] + ATAN_S;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (en) begin
            ctl_ff[s] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s] <= x_in;
            y_ff[s] <= y_in;
            z_ff[s] <= z_in;
         end
      end
   end

   assign out_ctl = ctl_ff[STAGES-1];
   assign out_cos = x_ff[STAGES-1];
   assign out_sin = y_ff[STAGES-1];

endmodule
`default_nettype wire

/* sv/gcrf_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module gcrf_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  gcrf_pkg::ctl_type             in_ctl,
   input  logic [gcrf_pkg::AW-1:0]       in_val   [gcrf_pkg::SQRT_LANES],
   output gcrf_pkg::ctl_type             out_ctl,
   output logic [gcrf_pkg::ROOT_W-1:0]   out_root [gcrf_pkg::SQRT_LANES]
);

   localparam int L  = gcrf_pkg::SQRT_LANES;
   localparam int RW = gcrf_pkg::ROOT_W;
   localparam int NW = gcrf_pkg::REM_W;

   logic [NW-1:0]     rem_ff  [RW][L];
   logic [RW-1:0]     root_ff [RW][L];
   gcrf_pkg::ctl_type ctl_ff  [RW];

   // one result bit per stage, most significant first
   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int K = RW - 1 - s;
      logic [NW-1:0]     rem_prev  [L];
      logic [RW-1:0]     root_prev [L];
      gcrf_pkg::ctl_type ctl_prev;
      logic [NW-1:0]     rem_in    [L];
      logic [RW-1:0]     root_in   [L];
      logic [NW:0]       delta     [L];

      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < L; l++) begin
               rem_prev[l]  = {in_val[l], {(NW - gcrf_pkg::AW){1'b0}}};
               root_prev[l] = '0;
            end
            ctl_prev = in_ctl;
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < L; l++) begin
               rem_prev[l]  = rem_ff[s-1][l];
               root_prev[l] = root_ff[s-1][l];
            end
            ctl_prev = ctl_ff[s-1];
         end
      end

      // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
      always_comb begin
         for (int l = 0; l < L; l++) begin
            delta[l] = ((NW+1)'(root_prev[l]) << (K + 1)) | ((NW+1)'(1) << (2 * K));
            if ({1'b0, rem_prev[l]} >= delta[l]) begin
               rem_in[l]  = NW'({1'b0, rem_prev[l]} - delta[l]);
               root_in[l] = root_prev[l] | (RW'(1) << K);
            end else begin
               rem_in[l]  = rem_prev[l];
               root_in[l] = root_prev[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (en) begin
            ctl_ff[s] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

   assign out_ctl  = ctl_ff[RW-1];
   assign out_root = root_ff[RW-1];

endmodule
`default_nettype wire

/* sv/gcrf_cordic_vec.sv */
`timescale 1ns / 1ps
`default_nettype none
module gcrf_cordic_vec #(
   parameter int STAGES = gcrf_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  gcrf_pkg::ctl_type in_ctl,
   input  gcrf_pkg::cw_type  in_x,
   input  gcrf_pkg::cw_type  in_y,
   output gcrf_pkg::ctl_type out_ctl,
   output gcrf_pkg::cw_type  out_angle
);

   gcrf_pkg::cw_type  x_ff [STAGES];
   gcrf_pkg::cw_type  y_ff [STAGES];
   gcrf_pkg::cw_type  z_ff [STAGES];
   gcrf_pkg::ctl_type ctl_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam gcrf_pkg::cw_type ATAN_S = gcrf_pkg::atan_q30(s);
      gcrf_pkg::cw_type  x_prev, y_prev, z_prev;
      gcrf_pkg::ctl_type ctl_prev;
      gcrf_pkg::cw_type  x_in, y_in, z_in;

      if (s == 0) begin : g_first
         always_comb begin
            x_prev   = in_x;
            y_prev   = in_y;
            z_prev   = '0;
            ctl_prev = in_ctl;
         end
      end else begin : g_next
         always_comb begin
            x_prev   = x_ff[s-1];
            y_prev   = y_ff[s-1];
            z_prev   = z_ff[s-1];
            ctl_prev = ctl_ff[s-1];
         end
      end

      // drive y toward zero, accumulate the angle
      always_comb begin
         if (y_prev > 0) begin
            x_in = x_prev + (y_prev >>> s);
            y_in = y_prev - (x_prev >>> s);
            z_in = z_prev + ATAN_S;
         end else begin
            x_in = x_prev - (y_prev >>> s);
            y_in = y_prev + (x_prev >>> s);
            z_in = z_prev - ATAN_S;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (en) begin
            ctl_ff[s] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s] <= x_in;
            y_ff[s] <= y_in;
            z_ff[s] <= z_in;
         end
      end
   end

   assign out_ctl   = ctl_ff[STAGES-1];
   assign out_angle = z_ff[STAGES-1];

endmodule
`default_nettype wire

/* sv/great_circle_radius_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall point_lat, point_lng
// rsp      out        rsp_valid/rsp_stall in_range, distance_m, has_position
// csr      in         csr_we              csr_addr, csr_wdata
//
// One point per cycle while the result is not stalled; the depth is set by
// the two CORDIC chains (one stage per iteration) and the 31-stage square root.
// Reset clears the valid bits of every stage and the configuration registers.
// A stalled result holds the whole pipeline and the input channel.
module great_circle_radius_filter_unit #(
   parameter int CORDIC_STAGES = gcrf_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [gcrf_pkg::LAT_W-1:0] req_point_lat,
   input  logic signed [gcrf_pkg::LNG_W-1:0] req_point_lng,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_in_range,
   output logic [gcrf_pkg::DIST_W-1:0]       rsp_distance_m,
   output logic                              rsp_has_position,
   input  logic                              csr_we,
   input  logic [gcrf_pkg::CSR_AW-1:0]       csr_addr,
   input  logic [gcrf_pkg::CSR_DW-1:0]       csr_wdata
);

   localparam int LAT_W  = gcrf_pkg::LAT_W;
   localparam int LNG_W  = gcrf_pkg::LNG_W;
   localparam int DIST_W = gcrf_pkg::DIST_W;
   localparam int CW     = gcrf_pkg::CW;
   localparam int MW     = gcrf_pkg::MW;
   localparam int AW     = gcrf_pkg::AW;
   localparam int RW     = gcrf_pkg::ROOT_W;
   localparam int L      = gcrf_pkg::ROT_LANES;
   localparam int PW     = 54;

   logic en;

   // configuration
   logic signed [LAT_W-1:0] center_lat_ff;
   logic signed [LNG_W-1:0] center_lng_ff;
   logic [DIST_W-1:0]       radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_lat_ff <= '0;
         center_lng_ff <= '0;
         radius_ff     <= '0;
      end else if (csr_we) begin
         unique case (gcrf_pkg::csr_idx_type'(csr_addr))
            gcrf_pkg::CSR_CENTER_LAT: center_lat_ff <= csr_wdata[LAT_W-1:0];
            gcrf_pkg::CSR_CENTER_LNG: center_lng_ff <= csr_wdata[LNG_W-1:0];
            gcrf_pkg::CSR_RADIUS:     radius_ff     <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // advance all stages unless the result is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // stage F1: clamp latitudes, raw longitude difference
   gcrf_pkg::ctl_type       f1_ctl_ff, f1_ctl_in;
   logic signed [LAT_W-1:0] f1_latc_ff, f1_latp_ff;
   logic signed [LNG_W:0]   f1_dlng_ff;

   always_comb begin
      f1_ctl_in.valid   = req_valid;
      f1_ctl_in.has_pos = (req_point_lat != '0) || (req_point_lng != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ctl_ff <= '0;
      end else if (en) begin
         f1_ctl_ff <= f1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_latc_ff <= gcrf_pkg::clamp_lat(center_lat_ff);
         f1_latp_ff <= gcrf_pkg::clamp_lat(req_point_lat);
         f1_dlng_ff <= (LNG_W+1)'(req_point_lng) - (LNG_W+1)'(center_lng_ff);
      end
   end

   // stage F2: latitude difference, wrap longitude into one turn
   gcrf_pkg::ctl_type       f2_ctl_ff;
   logic signed [LAT_W-1:0] f2_latc_ff, f2_latp_ff;
   logic signed [LNG_W-1:0] f2_dlat_ff, f2_dlng_ff, f2_dlng_in;
   logic signed [31:0]      f2_shift;

   always_comb begin
      f2_shift = 32'(f1_dlng_ff) + gcrf_pkg::LNG_HALF_TURN;
      if (f2_shift < 0) begin
         f2_dlng_in = LNG_W'(32'(f1_dlng_ff) + gcrf_pkg::LNG_TURN);
      end else if (f2_shift >= gcrf_pkg::LNG_TURN) begin
         f2_dlng_in = LNG_W'(32'(f1_dlng_ff) - gcrf_pkg::LNG_TURN);
      end else begin
         f2_dlng_in = LNG_W'(f1_dlng_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_ctl_ff <= '0;
      end else if (en) begin
         f2_ctl_ff <= f1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_latc_ff <= f1_latc_ff;
         f2_latp_ff <= f1_latp_ff;
         f2_dlat_ff <= LNG_W'(f1_latp_ff) - LNG_W'(f1_latc_ff);
         f2_dlng_ff <= f2_dlng_in;
      end
   end

   // stage F3: partial products of the degree-to-radian scaling
   gcrf_pkg::ctl_type       f3_ctl_ff;
   logic signed [LNG_W-1:0] f3_src [L];
   logic signed [46:0]      f3_hi_ff [L];
   logic signed [45:0]      f3_lo_ff [L];

   always_comb begin
      f3_src[0] = LNG_W'(f2_latc_ff);
      f3_src[1] = LNG_W'(f2_latp_ff);
      f3_src[2] = f2_dlat_ff;
      f3_src[3] = f2_dlng_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_ctl_ff <= '0;
      end else if (en) begin
         f3_ctl_ff <= f2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < L; l++) begin
            f3_hi_ff[l] <= 47'(f3_src[l]) * 47'(gcrf_pkg::DEG_RAD_HI);
            f3_lo_ff[l] <= 46'(f3_src[l]) * 46'(gcrf_pkg::DEG_RAD_LO);
         end
      end
   end

   // stage F4: combine and scale to Q2.30 (half angles for the differences)
   gcrf_pkg::ctl_type  f4_ctl_ff;
   gcrf_pkg::cw_type   f4_theta_ff [L];
   gcrf_pkg::cw_type   f4_theta_in [L];
   logic signed [63:0] f4_full [L];

   always_comb begin
      for (int l = 0; l < L; l++) begin
         f4_full[l] = (64'(f3_hi_ff[l]) <<< 16) + 64'(f3_lo_ff[l]);
         if (l < 2) begin
            f4_theta_in[l] = CW'(f4_full[l] >>> 28);
         end else begin
            f4_theta_in[l] = CW'(f4_full[l] >>> 29);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f4_ctl_ff <= '0;
      end else if (en) begin
         f4_ctl_ff <= f3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f4_theta_ff <= f4_theta_in;
      end
   end

   // sine and cosine
   gcrf_pkg::ctl_type rot_ctl;
   gcrf_pkg::cw_type  rot_cos [L];
   gcrf_pkg::cw_type  rot_sin [L];

   gcrf_cordic_rot #(
      .STAGES(CORDIC_STAGES)
   ) u_rot (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (f4_ctl_ff),
      .in_theta (f4_theta_ff),
      .out_ctl  (rot_ctl),
      .out_cos  (rot_cos),
      .out_sin  (rot_sin)
   );

   // stage M1: first products
   gcrf_pkg::ctl_type    m1_ctl_ff;
   logic signed [MW-1:0] m_c1, m_c2, m_s1, m_s2;
   logic signed [63:0]   m1_pa, m1_pb, m1_pc;
   logic signed [MW-1:0] m1_ss1_ff, m1_cc_ff, m1_ss2_ff;

   always_comb begin
      m_c1  = MW'(rot_cos[0]);
      m_c2  = MW'(rot_cos[1]);
      m_s1  = MW'(rot_sin[2]);
      m_s2  = MW'(rot_sin[3]);
      m1_pa = 64'(m_s1) * 64'(m_s1);
      m1_pb = 64'(m_c1) * 64'(m_c2);
      m1_pc = 64'(m_s2) * 64'(m_s2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ctl_ff <= '0;
      end else if (en) begin
         m1_ctl_ff <= rot_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ss1_ff <= MW'(m1_pa >>> 30);
         m1_cc_ff  <= MW'(m1_pb >>> 30);
         m1_ss2_ff <= MW'(m1_pc >>> 30);
      end
   end

   // stage M2: cos*cos*sin^2
   gcrf_pkg::ctl_type    m2_ctl_ff;
   logic signed [63:0]   m2_p;
   logic signed [MW-1:0] m2_ss1_ff, m2_t_ff;

   assign m2_p = 64'(m1_cc_ff) * 64'(m1_ss2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_ctl_ff <= '0;
      end else if (en) begin
         m2_ctl_ff <= m1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ss1_ff <= m1_ss1_ff;
         m2_t_ff   <= MW'(m2_p >>> 30);
      end
   end

   // stage M3: a clamped to [0, 1] and 1 - a
   gcrf_pkg::ctl_type    m3_ctl_ff;
   logic signed [MW:0]   m3_sum;
   logic [AW-1:0]        m3_a;
   logic [AW-1:0]        m3_val_ff [gcrf_pkg::SQRT_LANES];

   always_comb begin
      m3_sum = (MW+1)'(m2_ss1_ff) + (MW+1)'(m2_t_ff);
      if (m3_sum < 0) begin
         m3_a = '0;
      end else if (m3_sum > (MW+1)'(gcrf_pkg::Q30_ONE)) begin
         m3_a = gcrf_pkg::Q30_ONE;
      end else begin
         m3_a = AW'(m3_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_ctl_ff <= '0;
      end else if (en) begin
         m3_ctl_ff <= m2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_val_ff[0] <= m3_a;
         m3_val_ff[1] <= gcrf_pkg::Q30_ONE - m3_a;
      end
   end

   // square roots
   gcrf_pkg::ctl_type sq_ctl;
   logic [RW-1:0]     sq_root [gcrf_pkg::SQRT_LANES];

   gcrf_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctl   (m3_ctl_ff),
      .in_val   (m3_val_ff),
      .out_ctl  (sq_ctl),
      .out_root (sq_root)
   );

   // central half angle
   gcrf_pkg::ctl_type vec_ctl;
   gcrf_pkg::cw_type  vec_angle;

   gcrf_cordic_vec #(
      .STAGES(CORDIC_STAGES)
   ) u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (sq_ctl),
      .in_x      (gcrf_pkg::cw_type'(sq_root[1])),
      .in_y      (gcrf_pkg::cw_type'(sq_root[0])),
      .out_ctl   (vec_ctl),
      .out_angle (vec_angle)
   );

   // stage D1: scale by the earth radius
   gcrf_pkg::ctl_type d1_ctl_ff;
   logic [30:0]       d1_h;
   logic [PW-1:0]     d1_prod_ff;

   assign d1_h = (vec_angle < 0) ? '0 : vec_angle[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ctl_ff <= '0;
      end else if (en) begin
         d1_ctl_ff <= vec_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_prod_ff <= PW'(d1_h) * PW'(gcrf_pkg::EARTH_RADIUS_M);
      end
   end

   // stage D2: saturate, compare, output register
   gcrf_pkg::ctl_type rsp_ctl_ff;
   logic [DIST_W-1:0] d2_raw, d2_dist;
   logic              rsp_in_range_ff;
   logic [DIST_W-1:0] rsp_distance_ff;

   always_comb begin
      d2_raw  = DIST_W'(d1_prod_ff >> 29);
      d2_dist = (d2_raw > gcrf_pkg::DIST_MAX) ? gcrf_pkg::DIST_MAX : d2_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ctl_ff <= '0;
      end else if (en) begin
         rsp_ctl_ff <= d1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_in_range_ff <= d1_ctl_ff.has_pos && (d2_dist <= radius_ff);
         rsp_distance_ff <= d1_ctl_ff.has_pos ? d2_dist : '0;
      end
   end

   assign rsp_valid        = rsp_ctl_ff.valid;
   assign rsp_has_position = rsp_ctl_ff.has_pos;
   assign rsp_in_range     = rsp_in_range_ff;
   assign rsp_distance_m   = rsp_distance_ff;

endmodule
`default_nettype wire

/* sv/gcrf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "great_circle_radius_filter_unit_macros.svh"
module gcrf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic signed [gcrf_pkg::LAT_W-1:0] req_point_lat,
   input logic signed [gcrf_pkg::LNG_W-1:0] req_point_lng,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_in_range,
   input logic [gcrf_pkg::DIST_W-1:0]       rsp_distance_m,
   input logic                              rsp_has_position,
   input logic                              csr_we,
   input logic [gcrf_pkg::CSR_AW-1:0]       csr_addr,
   input logic [gcrf_pkg::CSR_DW-1:0]       csr_wdata
);

   `GCRF_ASSERT_NOW(a_range_needs_pos, rsp_valid && rsp_in_range, rsp_has_position, "in_range without position")
   `GCRF_ASSERT_NOW(a_nopos_zero, rsp_valid && !rsp_has_position, rsp_distance_m == '0, "distance set without position")
   `GCRF_ASSERT_NOW(a_dist_max, rsp_valid, rsp_distance_m <= gcrf_pkg::DIST_MAX, "distance above maximum")
   `GCRF_ASSERT_NOW(a_stall_source, 1'b1, req_stall == (rsp_valid && rsp_stall), "input held without output stall")
   `GCRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_distance_m), "stalled result changed")

endmodule

bind great_circle_radius_filter_unit gcrf_checker u_checker (.*);
`default_nettype wire

/* test/tb_great_circle_radius_filter_unit.sv */
`timescale 1ns / 1ps
module tb_great_circle_radius_filter_unit;

   localparam int LAT_W  = gcrf_pkg::LAT_W;
   localparam int LNG_W  = gcrf_pkg::LNG_W;
   localparam int DIST_W = gcrf_pkg::DIST_W;
   localparam int CSR_AW = gcrf_pkg::CSR_AW;
   localparam int CSR_DW = gcrf_pkg::CSR_DW;
   localparam int STAGES = gcrf_pkg::CORDIC_STAGES_DEF;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 2 * STAGES + 60;
   localparam int HOLD_CYCLES = 400;
   localparam logic [CSR_AW-1:0] CSR_UNUSED = 2'd3;
   localparam int ITEMS_PER_PHASE = 250;
   localparam longint DEG_Q28 = 64'sd5030569069;

   typedef struct packed {
      bit           in_range;
      bit [24:0]    distance_m;
      bit           has_position;
   } fix_result_type;

   class fence_scoreboard;
      logic signed [LAT_W-1:0] cfg_lat;
      logic signed [LNG_W-1:0] cfg_lng;
      logic [DIST_W-1:0]       cfg_radius;
      fix_result_type          expected_fixes[$];
      int                      mismatches;

      function new();
         cfg_lat = '0;
         cfg_lng = '0;
         cfg_radius = '0;
         mismatches = 0;
      endfunction

      function longint arctan_step(int i);
         longint lead[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                              33543515, 16775850, 8388437, 4194282, 2097149};
         if (i < 10) return lead[i];
         if (i < 30) return (longint'(1) <<< (30 - i)) - 1;
         return 0;
      endfunction

      function void rotate(longint theta, output longint c, output longint s);
         longint x, y, z, dx, dy;
         x = 652032874;
         y = 0;
         z = theta;
         for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= arctan_step(i);
            end else begin
               x += dx; y -= dy; z += arctan_step(i);
            end
         end
         c = x;
         s = y;
      endfunction

      function longint vector_angle(longint x, longint y);
         longint z, dx, dy;
         z = 0;
         for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx; y -= dy; z += arctan_step(i);
            end else begin
               x -= dx; y += dy; z -= arctan_step(i);
            end
         end
         return z;
      endfunction

      function longint unsigned floor_sqrt(longint unsigned n);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function longint sat_lat(longint v);
         if (v > 90000000) return 90000000;
         if (v < -90000000) return -90000000;
         return v;
      endfunction

      function longint q30_mul(longint a, longint b);
         return (a * b) >>> 30;
      endfunction

      function void note_point(logic signed [LAT_W-1:0] plat, logic signed [LNG_W-1:0] plng);
         longint latc, latp, dlat, dlng, c1, c2, s1, s2, unused, a, ys, xs, h;
         longint unsigned dist_m;
         fix_result_type r;
         r = '0;
         if (plat != 0 || plng != 0) begin
            latc = sat_lat(longint'(cfg_lat));
            latp = sat_lat(longint'(plat));
            dlat = latp - latc;
            dlng = longint'(plng) - longint'(cfg_lng) + 180000000;
            dlng = ((dlng % 360000000) + 360000000) % 360000000 - 180000000;
            rotate((latc * DEG_Q28) >>> 28, c1, unused);
            rotate((latp * DEG_Q28) >>> 28, c2, unused);
            rotate((dlat * DEG_Q28) >>> 29, unused, s1);
            rotate((dlng * DEG_Q28) >>> 29, unused, s2);
            a = q30_mul(s1, s1) + q30_mul(q30_mul(c1, c2), q30_mul(s2, s2));
            if (a < 0) a = 0;
            if (a > (longint'(1) << 30)) a = longint'(1) << 30;
            ys = longint'(floor_sqrt(longint'(a) << 30));
            xs = longint'(floor_sqrt(((longint'(1) << 30) - a) << 30));
            h = vector_angle(xs, ys);
            if (h < 0) h = 0;
            dist_m = (longint'(h) * 6371000) >> 29;
            if (dist_m > 20015087) dist_m = 20015087;
            r.in_range = (dist_m <= cfg_radius);
            r.distance_m = dist_m[24:0];
            r.has_position = 1'b1;
         end
         expected_fixes.push_back(r);
      endfunction

      function void check_fix(fix_result_type got);
         fix_result_type want;
         if (expected_fixes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: in_range=%0d distance=%0d has_position=%0d",
                        got.in_range, got.distance_m, got.has_position);
            return;
         end
         want = expected_fixes.pop_front();
         if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected in_range=%0d distance=%0d has_position=%0d, %s",
                        want.in_range, want.distance_m, want.has_position,
                        $sformatf("got in_range=%0d distance=%0d has_position=%0d",
                                  got.in_range, got.distance_m, got.has_position));
         end
      endfunction

      function int pending();
         return expected_fixes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [LAT_W-1:0] req_point_lat = '0;
   logic signed [LNG_W-1:0] req_point_lng = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_in_range;
   logic [DIST_W-1:0] rsp_distance_m;
   logic rsp_has_position;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   fence_scoreboard fence = new();
   bit calm = 1'b0;
   bit hold_request = 1'b0;
   int idle_cycles = 0;

   great_circle_radius_filter_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_lat(req_point_lat), .req_point_lng(req_point_lng),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_in_range(rsp_in_range), .rsp_distance_m(rsp_distance_m),
      .rsp_has_position(rsp_has_position),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random stalls, plus one long hold on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0: hold_left = $urandom_range(10, 40);
               1, 2, 3, 4: hold_left = $urandom_range(1, 3);
               default: hold_left = 0;
            endcase
            rsp_stall <= (hold_left > 0);
            if (hold_left > 0) hold_left--;
         end
      end
   end

   // inputs change only at rising edges, so the negedge sees what the next edge samples
   initial begin
      fix_result_type got;
      forever begin
         @(negedge clock);
         if (!reset) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (rsp_valid && !rsp_stall) begin
               got.in_range = rsp_in_range;
               got.distance_m = rsp_distance_m;
               got.has_position = rsp_has_position;
               fence.check_fix(got);
            end
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("simulation failed");
               $finish;
            end
         end
      end
   end

   task automatic write_csr(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         gcrf_pkg::CSR_CENTER_LAT: fence.cfg_lat = data[LAT_W-1:0];
         gcrf_pkg::CSR_CENTER_LNG: fence.cfg_lng = data[LNG_W-1:0];
         gcrf_pkg::CSR_RADIUS:     fence.cfg_radius = data[DIST_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // called at a rising edge; returns at the edge where the transfer happens, or after the random gap
   task automatic send_point(logic signed [LAT_W-1:0] lat, logic signed [LNG_W-1:0] lng);
      bit taken;
      int gap;
      req_valid <= 1'b1;
      req_point_lat <= lat;
      req_point_lng <= lng;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      fence.note_point(lat, lng);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (fence.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_point();
      int r, lat, lng;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         lat = int'($urandom_range(0, 180000000)) - 90000000;
         lng = int'($urandom_range(0, 360000000)) - 180000000;
      end else if (r < 82) begin
         lat = int'(fence.cfg_lat) + int'($urandom_range(0, 4000000)) - 2000000;
         lng = int'(fence.cfg_lng) + int'($urandom_range(0, 4000000)) - 2000000;
      end else if (r < 94) begin
         lat = int'($urandom());
         lng = int'($urandom());
         send_point(lat[LAT_W-1:0], lng[LNG_W-1:0]);
         return;
      end else begin
         lat = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 4)) - 2;
         lng = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 4)) - 2;
      end
      send_point(LAT_W'(lat), LNG_W'(lng));
   endtask

   initial begin
      int lat_set[7] = '{0, 90000000, -90000000, 134217727, -134217728, 37774929, 0};
      int lng_set[7] = '{0, 180000000, -180000000, 268435455, -268435456, -122419416, 0};
      int rad_set[7] = '{0, 20037509, 33554431, 20037509, 0, 5000000, 0};
      int anti_lng;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < 7; phase++) begin
         if (phase > 0) begin
            if (phase == 6) begin
               write_csr(gcrf_pkg::CSR_CENTER_LAT,
                         CSR_DW'(int'($urandom_range(0, 180000000)) - 90000000));
               write_csr(gcrf_pkg::CSR_CENTER_LNG,
                         CSR_DW'(int'($urandom_range(0, 360000000)) - 180000000));
               write_csr(gcrf_pkg::CSR_RADIUS, CSR_DW'($urandom_range(0, 20037509)));
            end else begin
               write_csr(gcrf_pkg::CSR_CENTER_LAT, CSR_DW'(lat_set[phase]));
               write_csr(gcrf_pkg::CSR_CENTER_LNG, CSR_DW'(lng_set[phase]));
               write_csr(gcrf_pkg::CSR_RADIUS, CSR_DW'(rad_set[phase]));
            end
            if (phase == 2) write_csr(CSR_UNUSED, CSR_DW'($urandom()));
         end
         calm = (phase == 4);
         send_point(0, 0);
         send_point(0, 1);
         send_point(1, 0);
         send_point(-1, -1);
         send_point(90000000, 0);
         send_point(-90000000, 0);
         send_point(0, 180000000);
         send_point(0, -180000000);
         send_point(0, 179999999);
         send_point(134217727, 268435455);
         send_point(-134217728, -268435456);
         send_point(45000000, 90000000);
         send_point(-45000000, -90000000);
         send_point(90000000, 180000000);
         send_point(fence.cfg_lat, fence.cfg_lng);
         anti_lng = int'(fence.cfg_lng) + 180000000;
         if (anti_lng >= 180000000) anti_lng -= 360000000;
         send_point(-fence.cfg_lat, LNG_W'(anti_lng));
         if (phase == 3) hold_request = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_point();
         // pause the sender until every result is back
         drain();
      end
      if (fence.mismatches == 0 && fence.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
